### rtl/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared constants for the fixed-point to grouped decimal text formatter.
// ----------------------------------------------------------------------------
package fdt_pkg;

  localparam int VALUE_W = 48;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] SEP_RESET = 8'd39;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    digit_char = CH_ZERO | {4'b0000, d};
  endfunction

endpackage

### rtl/fdt_ifs.sv
// ----------------------------------------------------------------------------
// fdt_ifs
// Stream channels of the formatter: value in, text out, separator write.
// ----------------------------------------------------------------------------
interface fdt_value_if import fdt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface fdt_text_if import fdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              last_char;
  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface fdt_cfg_if import fdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] group_separator;
  modport source (output valid, output group_separator, input ready);
  modport sink   (input valid, input group_separator, output ready);
endinterface

### rtl/fdt_round.sv
// ----------------------------------------------------------------------------
// fdt_round
// Two stages: sign and magnitude, then scale by 100 and round to hundredths.
// ----------------------------------------------------------------------------
module fdt_round import fdt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int HUND_W    = VALUE_W + 7 - FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [HUND_W-1:0]         out_hund,
  output logic                      out_neg
);

  localparam int PROD_W = VALUE_W + 7;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic               a_valid;
  logic               a_neg;
  logic [VALUE_W-1:0] a_mag;
  logic [VALUE_W-1:0] raw;
  logic [PROD_W-1:0]  mag_w;
  logic [PROD_W-1:0]  prod;
  logic               a_adv;
  logic               b_adv;

  assign b_adv    = !out_valid || out_ready;
  assign a_adv    = !a_valid || b_adv;
  assign in_ready = a_adv;

  assign raw   = in_value;
  assign mag_w = PROD_W'(a_mag);
  // times 100 as 64 + 32 + 4
  assign prod  = (mag_w << 6) + (mag_w << 5) + (mag_w << 2) + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_adv) a_valid <= in_valid;
      if (b_adv) out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_neg <= raw[VALUE_W-1];
      a_mag <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
    end
    if (b_adv) begin
      out_neg  <= a_neg;
      out_hund <= prod[PROD_W-1:FRAC_BITS];
    end
  end

endmodule

### rtl/fdt_bcd.sv
// ----------------------------------------------------------------------------
// fdt_bcd
// Pipelined shift-and-add-3 conversion, up to four bits per register stage.
// ----------------------------------------------------------------------------
module fdt_bcd import fdt_pkg::*; #(
  parameter int HUND_W = 39,
  parameter int DIGITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [HUND_W-1:0]     in_hund,
  input  logic                  in_neg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [4*DIGITS-1:0]   out_bcd,
  output logic                  out_neg
);

  localparam int STEPS = 4;
  localparam int NST   = (HUND_W + STEPS - 1) / STEPS;

  logic                v   [NST];
  logic                adv [NST];
  logic [HUND_W-1:0]   bin [NST];
  logic [4*DIGITS-1:0] bcd [NST];
  logic                neg [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic                iv;
    logic [HUND_W-1:0]   ibin;
    logic [4*DIGITS-1:0] ibcd;
    logic                ineg;
    logic                nxt_ready;
    logic [HUND_W-1:0]   nbin;
    logic [4*DIGITS-1:0] nbcd;

    if (s == 0) begin : g_first
      assign iv   = in_valid;
      assign ibin = in_hund;
      assign ibcd = '0;
      assign ineg = in_neg;
    end else begin : g_next
      assign iv   = v[s-1];
      assign ibin = bin[s-1];
      assign ibcd = bcd[s-1];
      assign ineg = neg[s-1];
    end

    if (s == NST - 1) begin : g_tail
      assign nxt_ready = out_ready;
    end else begin : g_mid
      assign nxt_ready = adv[s+1];
    end

    assign adv[s] = !v[s] || nxt_ready;

    always_comb begin
      nbin = ibin;
      nbcd = ibcd;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < HUND_W) begin
          for (int d = 0; d < DIGITS; d++) begin
            if (nbcd[4*d +: 4] >= 4'd5) nbcd[4*d +: 4] = nbcd[4*d +: 4] + 4'd3;
          end
          nbcd = {nbcd[4*DIGITS-2:0], nbin[HUND_W-1]};
          nbin = {nbin[HUND_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (adv[s]) begin
        v[s] <= iv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        bin[s] <= nbin;
        bcd[s] <= nbcd;
        neg[s] <= ineg;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[NST-1];
  assign out_bcd   = bcd[NST-1];
  assign out_neg   = neg[NST-1];

endmodule

### rtl/fdt_fmt.sv
// ----------------------------------------------------------------------------
// fdt_fmt
// Lays out the digits right to left with point and separators, and works
// out the text length and the first character position.
// ----------------------------------------------------------------------------
module fdt_fmt import fdt_pkg::*; #(
  parameter int DIGITS      = 12,
  parameter int FIELD_CHARS = 16,
  parameter int REV_LEN     = 3 + (DIGITS - 2) + (DIGITS - 3) / 3,
  parameter int NW          = $clog2(REV_LEN + 2),
  parameter int BW          = $clog2(REV_LEN + FIELD_CHARS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [CHAR_W-1:0]               sep,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [4*DIGITS-1:0]             in_bcd,
  input  logic                            in_neg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [REV_LEN-1:0][CHAR_W-1:0]  out_rev,
  output logic                            out_neg,
  output logic [NW-1:0]                   out_n,
  output logic [BW-1:0]                   out_base
);

  localparam int DI = DIGITS - 2;

  logic [REV_LEN-1:0][CHAR_W-1:0] rev;
  logic [NW-1:0]                  len_int;
  logic                           neg_eff;
  logic [NW-1:0]                  n;
  logic [BW-1:0]                  base;
  logic                           adv;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    int p;
    rev     = '0;
    len_int = NW'(1);
    rev[0]  = digit_char(in_bcd[3:0]);
    rev[1]  = digit_char(in_bcd[7:4]);
    rev[2]  = CH_POINT;
    for (int k = 0; k < DI; k++) begin
      p = 3 + k + k / 3;
      rev[p] = digit_char(in_bcd[4*(k+2) +: 4]);
      if (k > 0 && k % 3 == 0) rev[p-1] = sep;
      // highest nonzero integer digit sets the length
      if (k > 0 && in_bcd[4*(k+2) +: 4] != 4'd0) len_int = NW'(k + 1 + k / 3);
    end
    neg_eff = in_neg && (in_bcd != '0);
    n       = NW'(3) + len_int + NW'(neg_eff);
    base    = (BW'(n) >= BW'(FIELD_CHARS)) ? BW'(n) - BW'(1) : BW'(FIELD_CHARS - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rev  <= rev;
      out_neg  <= neg_eff;
      out_n    <= n;
      out_base <= base;
    end
  end

endmodule

### rtl/fdt_ser.sv
// ----------------------------------------------------------------------------
// fdt_ser
// Holds one laid-out field and sends it one character per cycle, while the
// receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module fdt_ser import fdt_pkg::*; #(
  parameter int FIELD_CHARS = 16,
  parameter int REV_LEN     = 16,
  parameter int NW          = 5,
  parameter int BW          = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [REV_LEN-1:0][CHAR_W-1:0]  in_rev,
  input  logic                            in_neg,
  input  logic [NW-1:0]                   in_n,
  input  logic [BW-1:0]                   in_base,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [CHAR_W-1:0]               out_char,
  output logic                            out_last
);

  localparam int CW  = $clog2(FIELD_CHARS);
  localparam int RIW = $clog2(REV_LEN);
  localparam logic [CW-1:0] LAST_POS = CW'(FIELD_CHARS - 1);

  logic                           busy;
  logic [REV_LEN-1:0][CHAR_W-1:0] rev;
  logic                           neg;
  logic [NW-1:0]                  n;
  logic [BW-1:0]                  base;
  logic [CW-1:0]                  cnt;
  logic                           out_load;
  logic                           fin;
  logic [BW-1:0]                  idx;
  logic [CHAR_W-1:0]              ch;

  assign out_load = busy && (!out_valid || out_ready);
  assign fin      = out_load && (cnt == LAST_POS);
  assign in_ready = !busy || fin;
  assign idx      = base - BW'(cnt);

  always_comb begin
    if (idx >= BW'(n)) begin
      ch = CH_SPACE;
    end else if (neg && idx == BW'(n) - BW'(1)) begin
      ch = CH_MINUS;
    end else begin
      ch = rev[idx[RIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) cnt <= fin ? '0 : cnt + CW'(1);
      if (in_ready) busy <= in_valid;
      if (!out_valid || out_ready) out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rev  <= in_rev;
      neg  <= in_neg;
      n    <= in_n;
      base <= in_base;
    end
    if (out_load) begin
      out_char <= ch;
      out_last <= (cnt == LAST_POS);
    end
  end

endmodule

### rtl/fixed_to_grouped_decimal_text.sv
// ----------------------------------------------------------------------------
// fixed_to_grouped_decimal_text
// Signed fixed-point value to right-justified grouped decimal ASCII field.
// ----------------------------------------------------------------------------
// num:  one signed value per item, FRAC_BITS fraction bits, rounded to
//       hundredths half away from zero
// text: FIELD_CHARS characters per value, left to right, last_char on the
//       final one; a value rounding to zero prints unsigned 0.00
// cfg:  writes the group separator character, always ready
// the value passes 2 rounding stages, ceil((55 - FRAC_BITS) / 4) conversion
// stages (10 at default), one layout stage and the serializer
// the output register sends a single character per cycle while the receiver
// is ready and so sets the throughput; each rounding, conversion and layout
// stage can hold one waiting value while the serializer works
// a stalled receiver holds the output register and backs the stages up,
// nothing is dropped or repeated
// reset empties every stage and sets the separator to an apostrophe
// ----------------------------------------------------------------------------
module fixed_to_grouped_decimal_text import fdt_pkg::*; #(
  parameter int FIELD_CHARS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  fdt_value_if.sink     num,
  fdt_text_if.source    text,
  fdt_cfg_if.sink       cfg
);

  localparam int HUND_W  = VALUE_W + 7 - FRAC_BITS;
  localparam int DIGITS  = ((HUND_W * 1233) >> 12) + 1;
  localparam int REV_LEN = 3 + (DIGITS - 2) + (DIGITS - 3) / 3;
  localparam int NW      = $clog2(REV_LEN + 2);
  localparam int BW      = $clog2(REV_LEN + FIELD_CHARS + 1);

  logic [CHAR_W-1:0] sep;

  logic                           r_valid, r_ready;
  logic [HUND_W-1:0]              r_hund;
  logic                           r_neg;
  logic                           b_valid, b_ready;
  logic [4*DIGITS-1:0]            b_bcd;
  logic                           b_neg;
  logic                           f_valid, f_ready;
  logic [REV_LEN-1:0][CHAR_W-1:0] f_rev;
  logic                           f_neg;
  logic [NW-1:0]                  f_n;
  logic [BW-1:0]                  f_base;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep <= SEP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      sep <= cfg.group_separator;
    end
  end

  fdt_round #(.FRAC_BITS(FRAC_BITS), .HUND_W(HUND_W)) u_round (
    .clk(clk), .rst(rst),
    .in_valid(num.valid), .in_ready(num.ready), .in_value(num.value),
    .out_valid(r_valid), .out_ready(r_ready), .out_hund(r_hund), .out_neg(r_neg)
  );

  fdt_bcd #(.HUND_W(HUND_W), .DIGITS(DIGITS)) u_bcd (
    .clk(clk), .rst(rst),
    .in_valid(r_valid), .in_ready(r_ready), .in_hund(r_hund), .in_neg(r_neg),
    .out_valid(b_valid), .out_ready(b_ready), .out_bcd(b_bcd), .out_neg(b_neg)
  );

  fdt_fmt #(
    .DIGITS(DIGITS), .FIELD_CHARS(FIELD_CHARS), .REV_LEN(REV_LEN), .NW(NW), .BW(BW)
  ) u_fmt (
    .clk(clk), .rst(rst), .sep(sep),
    .in_valid(b_valid), .in_ready(b_ready), .in_bcd(b_bcd), .in_neg(b_neg),
    .out_valid(f_valid), .out_ready(f_ready), .out_rev(f_rev), .out_neg(f_neg),
    .out_n(f_n), .out_base(f_base)
  );

  fdt_ser #(
    .FIELD_CHARS(FIELD_CHARS), .REV_LEN(REV_LEN), .NW(NW), .BW(BW)
  ) u_ser (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_rev(f_rev), .in_neg(f_neg),
    .in_n(f_n), .in_base(f_base),
    .out_valid(text.valid), .out_ready(text.ready),
    .out_char(text.text_char), .out_last(text.last_char)
  );

  // output register empties on reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !text.valid)
    else $error("output valid after reset");

  // a field goes out without gaps once started
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.ready && !text.last_char |=> text.valid)
    else $error("gap inside a field");

endmodule
